[rtl/core/fcr_pkg.sv]
// Shared types and constants for the framed command receiver.
// No dependencies; used by framed_command_receiver.
package fcr_pkg;

  localparam int PAYLOAD_MAX_DEFAULT = 32;

  localparam logic [7:0] HDR_FIRST  = 8'hFD;
  localparam logic [7:0] HDR_SECOND = 8'hDF;

  localparam logic [7:0] CMD_REQ_A = 8'd1;
  localparam logic [7:0] CMD_REQ_B = 8'd2;
  localparam logic [7:0] CMD_STORE = 8'd3;
  localparam logic [7:0] CMD_REQ_D = 8'd4;

  localparam logic [2:0] REQ_NONE  = 3'd0;
  localparam logic [2:0] REQ_STORE = 3'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_CMD    = 2'd1,
    PH_LEN    = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_HEADER  = 2'd1,
    ERR_COMMAND = 2'd2,
    ERR_LENGTH  = 2'd3
  } err_t;

endpackage

[rtl/core/framed_command_receiver.sv]
// Framed command receiver: parses 0xFD 0xDF, command, length, payload frames.
// Depends on fcr_pkg for the phase and error types and the frame constants.
// The result word for an input byte is presented in the cycle after it is accepted.
// One byte per cycle unless the output stalls; parser state and result update together.
// The output register frees the input as soon as its word is taken or it is empty.
// Reset (synchronous, active high) returns to the header search with no request and
// no pending store, and empties the output register.
module framed_command_receiver #(
  parameter int PAYLOAD_MAX = fcr_pkg::PAYLOAD_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] request, [3] store_pending,
                                      // [8:4] payload_index, [16:9] payload_byte,
                                      // [23:17] zero
  output logic        m_axis_tlast,   // frame_done
  output logic [2:0]  m_axis_tuser    // [0] payload_valid, [2:1] error_code
);

  localparam logic [7:0] LenMax = 8'(PAYLOAD_MAX);

  fcr_pkg::phase_t phase, phase_next;
  logic [5:0] byte_count, byte_count_next;
  logic [5:0] frame_length, frame_length_next;
  logic [2:0] current_request, current_request_next;
  logic       pending_store, pending_store_next;

  logic       accept;
  logic [5:0] count_inc;
  logic       frame_done_c;
  logic       payload_valid_c;
  logic [4:0] payload_index_c;
  fcr_pkg::err_t error_code_c;

  logic       out_valid;
  logic       frame_done;
  logic [2:0] request;
  logic       store_pending;
  logic       payload_valid;
  logic [4:0] payload_index;
  logic [7:0] payload_byte;
  fcr_pkg::err_t error_code;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign count_inc     = byte_count + 6'd1;

  // Next parser state.
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    frame_length_next    = frame_length;
    current_request_next = current_request;
    pending_store_next   = pending_store;
    unique case (phase)
      fcr_pkg::PH_HEADER: begin
        if (byte_count == 6'd0) begin
          if (s_axis_tdata == fcr_pkg::HDR_FIRST) begin
            byte_count_next = 6'd1;
          end
        end else begin
          // A wrong second byte is not reused as a new first header byte.
          byte_count_next = 6'd0;
          if (s_axis_tdata == fcr_pkg::HDR_SECOND) begin
            phase_next = fcr_pkg::PH_CMD;
          end
        end
      end
      fcr_pkg::PH_CMD: begin
        phase_next = fcr_pkg::PH_LEN;
        unique case (s_axis_tdata) inside
          fcr_pkg::CMD_REQ_A, fcr_pkg::CMD_REQ_B, fcr_pkg::CMD_REQ_D: begin
            current_request_next = s_axis_tdata[2:0];
            pending_store_next   = 1'b0;
          end
          fcr_pkg::CMD_STORE: begin
            current_request_next = fcr_pkg::REQ_NONE;
            pending_store_next   = 1'b1;
          end
          default: begin
            phase_next           = fcr_pkg::PH_HEADER;
            byte_count_next      = 6'd0;
            current_request_next = fcr_pkg::REQ_NONE;
            pending_store_next   = 1'b0;
          end
        endcase
      end
      fcr_pkg::PH_LEN: begin
        byte_count_next = 6'd0;
        if (s_axis_tdata > LenMax) begin
          phase_next           = fcr_pkg::PH_HEADER;
          current_request_next = fcr_pkg::REQ_NONE;
          pending_store_next   = 1'b0;
        end else if (s_axis_tdata == 8'd0) begin
          phase_next = fcr_pkg::PH_HEADER;
        end else begin
          frame_length_next = s_axis_tdata[5:0];
          phase_next        = fcr_pkg::PH_DATA;
        end
      end
      fcr_pkg::PH_DATA: begin
        byte_count_next = count_inc;
        if (count_inc >= frame_length) begin
          phase_next      = fcr_pkg::PH_HEADER;
          byte_count_next = 6'd0;
          if (pending_store) begin
            current_request_next = fcr_pkg::REQ_STORE;
            pending_store_next   = 1'b0;
          end
        end
      end
      default: begin
        phase_next = fcr_pkg::PH_HEADER;
      end
    endcase
  end

  // Per-byte result fields.
  always_comb begin
    frame_done_c    = 1'b0;
    payload_valid_c = 1'b0;
    payload_index_c = 5'd0;
    error_code_c    = fcr_pkg::ERR_NONE;
    unique case (phase)
      fcr_pkg::PH_HEADER: begin
        if (byte_count == 6'd0) begin
          if (s_axis_tdata != fcr_pkg::HDR_FIRST) begin
            error_code_c = fcr_pkg::ERR_HEADER;
          end
        end else if (s_axis_tdata != fcr_pkg::HDR_SECOND) begin
          error_code_c = fcr_pkg::ERR_HEADER;
        end
      end
      fcr_pkg::PH_CMD: begin
        unique case (s_axis_tdata) inside
          fcr_pkg::CMD_REQ_A, fcr_pkg::CMD_REQ_B, fcr_pkg::CMD_STORE,
          fcr_pkg::CMD_REQ_D: error_code_c = fcr_pkg::ERR_NONE;
          default:            error_code_c = fcr_pkg::ERR_COMMAND;
        endcase
      end
      fcr_pkg::PH_LEN: begin
        if (s_axis_tdata > LenMax) begin
          error_code_c = fcr_pkg::ERR_LENGTH;
        end else if (s_axis_tdata == 8'd0) begin
          frame_done_c = 1'b1;
        end
      end
      fcr_pkg::PH_DATA: begin
        payload_valid_c = 1'b1;
        payload_index_c = byte_count[4:0];
        frame_done_c    = (count_inc >= frame_length);
      end
      default: begin
        error_code_c = fcr_pkg::ERR_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= fcr_pkg::PH_HEADER;
      byte_count      <= 6'd0;
      frame_length    <= 6'd0;
      current_request <= fcr_pkg::REQ_NONE;
      pending_store   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        byte_count      <= byte_count_next;
        frame_length    <= frame_length_next;
        current_request <= current_request_next;
        pending_store   <= pending_store_next;
        out_valid       <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_done    <= frame_done_c;
      request       <= current_request_next;
      store_pending <= pending_store_next;
      payload_valid <= payload_valid_c;
      payload_index <= payload_index_c;
      payload_byte  <= payload_valid_c ? s_axis_tdata : 8'd0;
      error_code    <= error_code_c;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, payload_byte, payload_index, store_pending, request};
  assign m_axis_tlast  = frame_done;
  assign m_axis_tuser  = {error_code, payload_valid};

endmodule

[verif/framed_command_receiver_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for framed_command_receiver: a table of directed bytes, then random frames,
// each result word checked against the table's expected word or a frame parser built in.
// Depends on fcr_pkg and the framed_command_receiver RTL.
module framed_command_receiver_test;

  localparam int PAYLOAD_MAX = fcr_pkg::PAYLOAD_MAX_DEFAULT;
  localparam int RANDOM_BYTES = 500;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [7:0] CMD_UNKNOWN = 8'hFF;

  typedef struct packed {
    logic           done;
    logic [2:0]     request;
    logic           store_pending;
    logic           pvalid;
    logic [4:0]     pindex;
    logic [7:0]     pbyte;
    fcr_pkg::err_t  err;
  } rx_word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    rx_word_t   want;
  } byte_row_t;

  localparam rx_word_t NO_WORD = '0;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [2:0] request, [3] store_pending,
                               // [8:4] payload_index, [16:9] payload_byte, [23:17] zero
  logic        m_axis_tlast;   // frame_done
  logic [2:0]  m_axis_tuser;   // [0] payload_valid, [2:1] error_code

  // Parser state mirrored by the predictor.
  fcr_pkg::phase_t rx_phase;
  logic [5:0]      rx_count;
  logic [5:0]      rx_length;
  logic [2:0]      rx_request;
  logic            rx_store_pending;

  rx_word_t  expected_words[$];
  byte_row_t directed_rows[$];
  int        errors = 0;
  int        words_checked = 0;
  int        bytes_sent = 0;
  int        idle_cycles = 0;
  bit        quiet = 1'b0;
  bit        held_long = 1'b0;

  framed_command_receiver #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic rx_word_t parse_byte(input logic [7:0] b);
    rx_word_t w;
    w = '0;
    case (rx_phase)
      fcr_pkg::PH_HEADER: begin
        if (rx_count == 6'd0) begin
          if (b == fcr_pkg::HDR_FIRST) rx_count = 6'd1;
          else w.err = fcr_pkg::ERR_HEADER;
        end else begin
          // A wrong second byte is not reused as a fresh first byte.
          rx_count = 6'd0;
          if (b == fcr_pkg::HDR_SECOND) rx_phase = fcr_pkg::PH_CMD;
          else w.err = fcr_pkg::ERR_HEADER;
        end
      end
      fcr_pkg::PH_CMD: begin
        rx_phase = fcr_pkg::PH_LEN;
        if (b == fcr_pkg::CMD_REQ_A || b == fcr_pkg::CMD_REQ_B || b == fcr_pkg::CMD_REQ_D) begin
          rx_request = b[2:0];
          rx_store_pending = 1'b0;
        end else if (b == fcr_pkg::CMD_STORE) begin
          rx_request = fcr_pkg::REQ_NONE;
          rx_store_pending = 1'b1;
        end else begin
          rx_phase = fcr_pkg::PH_HEADER;
          rx_count = 6'd0;
          rx_request = fcr_pkg::REQ_NONE;
          rx_store_pending = 1'b0;
          w.err = fcr_pkg::ERR_COMMAND;
        end
      end
      fcr_pkg::PH_LEN: begin
        if (b > PAYLOAD_MAX) begin
          rx_phase = fcr_pkg::PH_HEADER;
          rx_count = 6'd0;
          rx_request = fcr_pkg::REQ_NONE;
          rx_store_pending = 1'b0;
          w.err = fcr_pkg::ERR_LENGTH;
        end else if (b == 8'd0) begin
          rx_phase = fcr_pkg::PH_HEADER;
          rx_count = 6'd0;
          w.done = 1'b1;
        end else begin
          rx_count = 6'd0;
          rx_length = b[5:0];
          rx_phase = fcr_pkg::PH_DATA;
        end
      end
      default: begin
        w.pvalid = 1'b1;
        w.pindex = rx_count[4:0];
        w.pbyte = b;
        rx_count = rx_count + 6'd1;
        if (rx_count >= rx_length) begin
          rx_phase = fcr_pkg::PH_HEADER;
          rx_count = 6'd0;
          w.done = 1'b1;
          // A held store only becomes the request once its payload is complete.
          if (rx_store_pending) begin
            rx_request = fcr_pkg::REQ_STORE;
            rx_store_pending = 1'b0;
          end
        end
      end
    endcase
    w.request = rx_request;
    w.store_pending = rx_store_pending;
    return w;
  endfunction

  function automatic rx_word_t flag_word(input logic done, input logic [2:0] req,
                                         input logic sp, input fcr_pkg::err_t err);
    rx_word_t w;
    w = '0;
    w.done = done;
    w.request = req;
    w.store_pending = sp;
    w.err = err;
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input logic [7:0] b, input logic typed, input rx_word_t want);
    byte_row_t row;
    row.b = b;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Called at a rising edge; returns at the edge where the byte is taken.
  task automatic send_byte(input logic [7:0] b, input logic typed, input rx_word_t want);
    int gap;
    rx_word_t w;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(negedge clk); while (!s_axis_tready);
    w = parse_byte(b);
    expected_words.push_back(typed ? want : w);
    bytes_sent++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic send_random_frame();
    int r;
    int len;
    logic [7:0] cmd;
    if ($urandom_range(0, 9) == 0) quiet = !quiet;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
      return;
    end
    if (r < 14) begin
      send_byte(fcr_pkg::HDR_FIRST, 1'b0, NO_WORD);
      send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
      return;
    end
    send_byte(fcr_pkg::HDR_FIRST, 1'b0, NO_WORD);
    send_byte(fcr_pkg::HDR_SECOND, 1'b0, NO_WORD);
    r = $urandom_range(0, 99);
    if (r < 6) cmd = 8'($urandom_range(0, 255));
    else if (r < 9) cmd = 8'd0;
    else begin
      case ($urandom_range(0, 3))
        0: cmd = fcr_pkg::CMD_REQ_A;
        1: cmd = fcr_pkg::CMD_REQ_B;
        2: cmd = fcr_pkg::CMD_STORE;
        default: cmd = fcr_pkg::CMD_REQ_D;
      endcase
    end
    send_byte(cmd, 1'b0, NO_WORD);
    r = $urandom_range(0, 99);
    if (r < 8) len = PAYLOAD_MAX;
    else if (r < 16) len = $urandom_range(PAYLOAD_MAX + 1, 255);
    else if (r < 26) len = $urandom_range(7, PAYLOAD_MAX);
    else len = $urandom_range(0, 6);
    send_byte(8'(len), 1'b0, NO_WORD);
    while (rx_phase == fcr_pkg::PH_DATA)
      send_byte(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
  endtask

  task automatic report(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  task automatic check_word();
    rx_word_t want;
    if (expected_words.size() == 0) begin
      report("unexpected word", int'(m_axis_tdata), 0);
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (m_axis_tlast !== want.done)
      report("frame_done", int'(m_axis_tlast), int'(want.done));
    if (m_axis_tdata[2:0] !== want.request)
      report("request", int'(m_axis_tdata[2:0]), int'(want.request));
    if (m_axis_tdata[3] !== want.store_pending)
      report("store_pending", int'(m_axis_tdata[3]), int'(want.store_pending));
    if (m_axis_tuser[0] !== want.pvalid)
      report("payload_valid", int'(m_axis_tuser[0]), int'(want.pvalid));
    if (m_axis_tdata[8:4] !== want.pindex)
      report("payload_index", int'(m_axis_tdata[8:4]), int'(want.pindex));
    if (m_axis_tdata[16:9] !== want.pbyte)
      report("payload_byte", int'(m_axis_tdata[16:9]), int'(want.pbyte));
    if (m_axis_tuser[2:1] !== want.err)
      report("error_code", int'(m_axis_tuser[2:1]), int'(want.err));
    if (m_axis_tdata[23:17] !== 7'd0)
      report("tdata padding", int'(m_axis_tdata[23:17]), 0);
  endtask

  // Handshakes are judged at the falling edge, where every signal is settled.
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_word();
  end

  always @(negedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no word moved for %0d cycles", $time, idle_cycles);
      $display("** framed_command_receiver: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold that backs the block up.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      if (!held_long && words_checked >= 200) begin
        held_long = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    rx_phase = fcr_pkg::PH_HEADER;
    rx_count = 6'd0;
    rx_length = 6'd0;
    rx_request = fcr_pkg::REQ_NONE;
    rx_store_pending = 1'b0;

    // Noise and broken headers after reset.
    add_row(8'h00, 1'b1,
            flag_word(1'b0, fcr_pkg::REQ_NONE, 1'b0, fcr_pkg::ERR_HEADER));
    add_row(8'hFF, 1'b1,
            flag_word(1'b0, fcr_pkg::REQ_NONE, 1'b0, fcr_pkg::ERR_HEADER));
    add_row(fcr_pkg::HDR_FIRST, 1'b1,
            flag_word(1'b0, fcr_pkg::REQ_NONE, 1'b0, fcr_pkg::ERR_NONE));
    add_row(fcr_pkg::HDR_FIRST, 1'b1,
            flag_word(1'b0, fcr_pkg::REQ_NONE, 1'b0, fcr_pkg::ERR_HEADER));
    // Unknown command.
    add_row(fcr_pkg::HDR_FIRST, 1'b0, NO_WORD);
    add_row(fcr_pkg::HDR_SECOND, 1'b0, NO_WORD);
    add_row(CMD_UNKNOWN, 1'b1,
            flag_word(1'b0, fcr_pkg::REQ_NONE, 1'b0, fcr_pkg::ERR_COMMAND));
    // Store with an empty frame stays pending.
    add_row(fcr_pkg::HDR_FIRST, 1'b0, NO_WORD);
    add_row(fcr_pkg::HDR_SECOND, 1'b0, NO_WORD);
    add_row(fcr_pkg::CMD_STORE, 1'b0, NO_WORD);
    add_row(8'd0, 1'b0, NO_WORD);
    // A new command drops the pending store, then the longest length aborts.
    add_row(fcr_pkg::HDR_FIRST, 1'b0, NO_WORD);
    add_row(fcr_pkg::HDR_SECOND, 1'b0, NO_WORD);
    add_row(fcr_pkg::CMD_REQ_D, 1'b0, NO_WORD);
    add_row(8'd255, 1'b1,
            flag_word(1'b0, fcr_pkg::REQ_NONE, 1'b0, fcr_pkg::ERR_LENGTH));
    // Store with a two byte payload of extreme values.
    add_row(fcr_pkg::HDR_FIRST, 1'b0, NO_WORD);
    add_row(fcr_pkg::HDR_SECOND, 1'b0, NO_WORD);
    add_row(fcr_pkg::CMD_STORE, 1'b0, NO_WORD);
    add_row(8'd2, 1'b0, NO_WORD);
    add_row(8'h00, 1'b0, NO_WORD);
    add_row(8'hFF, 1'b0, NO_WORD);
    // Empty frame for the first request, then one past the length limit.
    add_row(fcr_pkg::HDR_FIRST, 1'b0, NO_WORD);
    add_row(fcr_pkg::HDR_SECOND, 1'b0, NO_WORD);
    add_row(fcr_pkg::CMD_REQ_A, 1'b0, NO_WORD);
    add_row(8'd0, 1'b0, NO_WORD);
    add_row(fcr_pkg::HDR_FIRST, 1'b0, NO_WORD);
    add_row(fcr_pkg::HDR_SECOND, 1'b0, NO_WORD);
    add_row(fcr_pkg::CMD_REQ_B, 1'b0, NO_WORD);
    add_row(8'(PAYLOAD_MAX + 1), 1'b1,
            flag_word(1'b0, fcr_pkg::REQ_NONE, 1'b0, fcr_pkg::ERR_LENGTH));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    while (bytes_sent < directed_rows.size() + RANDOM_BYTES) begin
      if (!paused && bytes_sent >= 300) begin
        paused = 1'b1;
        wait_drained();
      end
      send_random_frame();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("** framed_command_receiver: PASSED **");
    else $display("** framed_command_receiver: FAILED **");
    $finish;
  end

endmodule
